// ----- design/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg: two-step time sync matcher definitions
// Shared payload types, status and opcode constants, and table defaults.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int unsigned ENTRIES_DEF = 2;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    localparam logic OP_SYNC      = 1'b0;
    localparam logic OP_FOLLOW_UP = 1'b1;

    localparam logic [2:0] ST_SYNC    = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    typedef struct packed {
        logic               op;
        logic               length_ok;
        logic [15:0]        msg_id;
        logic [13:0]        source_addr;
        logic [31:0]        seconds;
        logic signed [31:0] correction;
        logic [63:0]        rx_stamp;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [13:0]        master_addr;
        logic [15:0]        match_id;
        logic [31:0]        match_seconds;
        logic signed [31:0] match_correction;
        logic [63:0]        sync_rx_stamp;
        logic [63:0]        utc_ns;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [13:0] master;
        logic [31:0] seconds;
        logic [63:0] rx_stamp;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } tbl_ctl_t;

endpackage

// ----- design/tsm_if.sv -----
// ----------------------------------------------------------------------------
// tsm_if: request and response channels
// Valid/ready channels carrying the matcher request and response payloads.
// ----------------------------------------------------------------------------
interface tsm_req_if;
    logic          valid;
    logic          ready;
    tsm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsm_rsp_if;
    logic          valid;
    logic          ready;
    tsm_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/tsm_table.sv -----
// ----------------------------------------------------------------------------
// tsm_table: sync entry table
// Round-robin sync storage with per-entry valid bits and one indexed read.
// ----------------------------------------------------------------------------
module tsm_table #(
    parameter int unsigned ENTRIES = tsm_pkg::ENTRIES_DEF,
    parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsm_pkg::tbl_ctl_t   ctl,
    input  tsm_pkg::entry_t     wr_entry,
    input  logic [IDX_W-1:0]    idx,
    output tsm_pkg::entry_t     rd_entry,
    output logic                rd_valid
);
    import tsm_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    entry_t             ent_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   slot_next;

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (ctl.clr_en)
        begin
            valid_next[idx] = 1'b0;
        end
        if (ctl.wr_en)
        begin
            valid_next[slot_reg] = 1'b1;
            slot_next = (slot_reg == LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            ent_reg[slot_reg] <= wr_entry;
        end
    end

    assign rd_entry = ent_reg[idx];
    assign rd_valid = valid_reg[idx];

endmodule

// ----- design/tsm_utc.sv -----
// ----------------------------------------------------------------------------
// tsm_utc: UTC nanosecond unit
// Two-stage unit: seconds-to-nanoseconds multiply, then signed correction
// with clamping at zero.
// ----------------------------------------------------------------------------
module tsm_utc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        seconds,
    input  logic signed [31:0] correction,
    output logic               done,
    output logic [63:0]        utc_ns
);
    import tsm_pkg::*;

    logic               mul_vld_reg;
    logic [61:0]        prod_reg;
    logic signed [31:0] corr_reg;
    logic               done_reg;
    logic [63:0]        utc_reg;

    logic [61:0]        prod_next;
    logic [32:0]        mag;
    logic [63:0]        base;
    logic [63:0]        mag64;
    logic [63:0]        utc_next;

    always_comb
    begin
        prod_next = {30'b0, seconds} * {32'b0, NS_PER_SEC};
        base      = {2'b0, prod_reg};
        mag       = {1'b0, ~corr_reg} + 33'd1;
        mag64     = {31'b0, mag};
        if (corr_reg[31])
        begin
            utc_next = (base > mag64) ? (base - mag64) : '0;
        end
        else
        begin
            utc_next = base + {32'b0, corr_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            prod_reg    <= '0;
            corr_reg    <= '0;
            utc_reg     <= '0;
        end
        else
        begin
            mul_vld_reg <= start;
            done_reg    <= mul_vld_reg;
            if (start)
            begin
                prod_reg <= prod_next;
                corr_reg <= correction;
            end
            if (mul_vld_reg)
            begin
                utc_reg <= utc_next;
            end
        end
    end

    assign done   = done_reg;
    assign utc_ns = utc_reg;

endmodule

// ----- design/two_step_time_sync_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// two_step_time_sync_matcher_unit: two-step time sync matcher
// Pairs sync and follow-up requests from the same master and reports the
// matched origin time as UTC nanoseconds.
// ----------------------------------------------------------------------------
// One request is handled at a time.
//
// Steps from one acceptance to the next:
// - Bad-length request: goes straight to the emit state.
// - Sync: the write state performs the table write, then the emit state.
// - Follow-up: walks the table one entry per cycle through a single compare
//   unit. On a match it waits in the calc state for the multiply/correct
//   unit, then goes to the emit state.
//
// In every case the response register is loaded at the same edge at which
// the request side becomes ready again. That register lets the next request be
// accepted while an earlier response still waits to be taken. A new
// response waits, and so holds the request side, only while the register
// is still full and rsp.ready is low.
module two_step_time_sync_matcher_unit #(
    parameter int unsigned ENTRIES = tsm_pkg::ENTRIES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    tsm_req_if.sink   req,
    tsm_rsp_if.source rsp
);
    import tsm_pkg::*;

    localparam int unsigned      IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SEARCH,
        S_CALC,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    tbl_ctl_t         ctl;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic             rd_valid;
    logic             hit;
    logic             utc_start;
    logic             utc_done;
    logic [63:0]      utc_ns;

    assign wr_entry.id       = req_reg.msg_id;
    assign wr_entry.master   = req_reg.source_addr;
    assign wr_entry.seconds  = req_reg.seconds;
    assign wr_entry.rx_stamp = req_reg.rx_stamp;

    tsm_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .wr_entry (wr_entry),
        .idx      (idx_reg),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    tsm_utc u_utc (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (utc_start),
        .seconds    (req_reg.seconds),
        .correction (req_reg.correction),
        .done       (utc_done),
        .utc_ns     (utc_ns)
    );

    assign hit = rd_valid && (rd_entry.id == req_reg.msg_id)
                 && (rd_entry.master == req_reg.source_addr);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        idx_next       = idx_reg;
        ctl            = '0;
        utc_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = req.data;
                    res_next = '0;
                    idx_next = '0;
                    if (!req.data.length_ok)
                    begin
                        res_next.status = ST_BADLEN;
                        state_next      = S_EMIT;
                    end
                    else if (req.data.op == OP_SYNC)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_WRITE:
            begin
                ctl.wr_en       = 1'b1;
                res_next.status = ST_SYNC;
                state_next      = S_EMIT;
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    ctl.clr_en = 1'b1;
                    if (rd_entry.seconds != req_reg.seconds)
                    begin
                        res_next.status = ST_DROPPED;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        res_next.status           = ST_MATCH;
                        res_next.master_addr      = rd_entry.master;
                        res_next.match_id         = req_reg.msg_id;
                        res_next.match_seconds    = req_reg.seconds;
                        res_next.match_correction = req_reg.correction;
                        res_next.sync_rx_stamp    = rd_entry.rx_stamp;
                        utc_start                 = 1'b1;
                        state_next                = S_CALC;
                    end
                end
                else if (idx_reg == LAST)
                begin
                    res_next.status = ST_NOMATCH;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CALC:
            begin
                if (utc_done)
                begin
                    res_next.utc_ns = utc_ns;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule
